[hw/rtl/mmscale_pkg.sv]
// shared widths, codes and types for the min-max scale-to-8-bit block
package mmscale_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int CFG_BITS    = 32;
  localparam int PIXEL_BITS  = 8;
  localparam int RUN_BITS    = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
  localparam int QCNT_BITS   = $clog2(PIXEL_BITS);
  localparam int CFG_IDX_BITS = 1;

  localparam logic [QCNT_BITS-1:0]    DIV_LAST  = QCNT_BITS'(PIXEL_BITS - 1);
  localparam logic [PIXEL_BITS-1:0]   PIXEL_MAX = '1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_START = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_START = CFG_IDX_BITS'(1);

  localparam logic signed [CFG_BITS-1:0] MIN_START_RST = CFG_BITS'(1000000);
  localparam logic signed [CFG_BITS-1:0] MAX_START_RST = CFG_BITS'(0);

  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_SCALE   = 1'b1;

  typedef logic signed [RUN_BITS-1:0] run_t;
  typedef logic signed [RUN_BITS:0]   diff_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX
  } state_t;

  typedef enum logic [1:0] {
    MODE_FLAT,
    MODE_LOW,
    MODE_HIGH,
    MODE_DIV
  } mode_t;

endpackage

[hw/rtl/min_max_scale_to_8bit.sv]
// top level: running min/max tracker and serial-divider contrast stretch to 8-bit pixels
//
// Two passes over the same sample array. A measure transaction (req_type 0) updates the
// running minimum and maximum in the cycle it is accepted and gives no result; first = 1
// reloads both from min_start / max_start before the sample is applied. A scale
// transaction (req_type 1) gives one result, pixel = floor(255*(x-min)/(max-min))
// clamped to 0..255, with degenerate set and pixel 0 when max equals min, and pixel 0
// when max is below min. A scale transaction occupies the block from its acceptance to
// the next acceptance: the accept cycle forms x-min and max-min, then a restoring
// divider produces one quotient bit per cycle, and the correction cycle (which can
// overlap the next acceptance) writes the output register. The output register
// decouples the result channel, so new transactions are taken while a result waits,
// until a second result would need the register. Configuration writes only take
// effect at the next first measure sample.
module min_max_scale_to_8bit (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // input channel
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic                                      in_req_type,
  input  logic                                      in_first,
  input  logic signed [mmscale_pkg::SAMPLE_BITS-1:0] in_sample,
  // result channel
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic [mmscale_pkg::PIXEL_BITS-1:0]        out_pixel,
  output logic                                      out_degenerate,
  // configuration write port
  input  logic                                      cfg_we,
  input  logic [mmscale_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [mmscale_pkg::CFG_BITS-1:0]          cfg_wdata
);

  localparam int RB = mmscale_pkg::RUN_BITS;
  localparam int PB = mmscale_pkg::PIXEL_BITS;

  // control and state registers
  mmscale_pkg::state_t state_r, state_nxt;
  logic [mmscale_pkg::QCNT_BITS-1:0] cnt_r;
  mmscale_pkg::run_t  min_start_r, max_start_r;
  mmscale_pkg::run_t  run_min_r, run_max_r;
  logic               out_valid_r;

  // divider datapath registers
  mmscale_pkg::diff_t d_r, r_r;
  logic [RB-1:0]      rem_r;
  logic [PB-1:0]      q_r;
  mmscale_pkg::mode_t mode_r;
  logic [PB-1:0]      pixel_r;
  logic               degenerate_r;

  logic               take;       // input transaction accepted
  logic               out_free;   // output register can be written this cycle
  logic               out_load;

  // sample widened to running-value width
  mmscale_pkg::run_t  x_ext;
  mmscale_pkg::run_t  min_base, max_base;
  mmscale_pkg::diff_t d_nxt, r_nxt;

  // one restoring step
  logic [RB:0]        rem_sh;
  logic [RB+1:0]      trial;
  logic               q_bit;

  mmscale_pkg::mode_t mode_nxt;
  logic [PB-1:0]      pix_nxt;

  assign out_free = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    out_load  = 1'b0;
    case (state_r)
      mmscale_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      mmscale_pkg::ST_DIV: begin
        if (cnt_r == mmscale_pkg::DIV_LAST) begin
          state_nxt = mmscale_pkg::ST_FIX;
        end
      end
      mmscale_pkg::ST_FIX: begin
        // correction and output write, overlapped with the next acceptance
        if (out_free) begin
          out_load  = 1'b1;
          in_stall  = 1'b0;
          state_nxt = mmscale_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mmscale_pkg::ST_IDLE;
      end
    endcase
    take = in_valid && !in_stall;
    if (take && in_req_type == mmscale_pkg::REQ_SCALE) begin
      state_nxt = mmscale_pkg::ST_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmscale_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_start_r <= mmscale_pkg::run_t'(mmscale_pkg::MIN_START_RST);
      max_start_r <= mmscale_pkg::run_t'(mmscale_pkg::MAX_START_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        mmscale_pkg::CFG_MIN_START: min_start_r <= mmscale_pkg::run_t'(signed'(cfg_wdata));
        mmscale_pkg::CFG_MAX_START: max_start_r <= mmscale_pkg::run_t'(signed'(cfg_wdata));
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- measure pass
  assign x_ext    = mmscale_pkg::run_t'(in_sample);
  assign min_base = in_first ? min_start_r : run_min_r;
  assign max_base = in_first ? max_start_r : run_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_min_r <= mmscale_pkg::run_t'(mmscale_pkg::MIN_START_RST);
      run_max_r <= mmscale_pkg::run_t'(mmscale_pkg::MAX_START_RST);
    end else if (take && in_req_type == mmscale_pkg::REQ_MEASURE) begin
      run_min_r <= (x_ext < min_base) ? x_ext : min_base;
      run_max_r <= (x_ext > max_base) ? x_ext : max_base;
    end
  end

  // ---------------------------------------------------------------- scale pass
  // offsets from the minimum, one bit wider so sign tells range order
  assign d_nxt = mmscale_pkg::diff_t'(x_ext) - mmscale_pkg::diff_t'(run_min_r);
  assign r_nxt = mmscale_pkg::diff_t'(run_max_r) - mmscale_pkg::diff_t'(run_min_r);

  // restoring step: rem stays below r, so the shifted value fits one extra bit
  assign rem_sh = {rem_r, 1'b0};
  assign trial  = {1'b0, rem_sh} - {2'b00, r_r[RB-1:0]};
  assign q_bit  = !trial[RB+1];

  // range classification, evaluated alongside the first quotient step
  always_comb begin
    if (r_r == '0) begin
      mode_nxt = mmscale_pkg::MODE_FLAT;
    end else if (r_r[RB] || d_r[RB] || d_r == '0) begin
      mode_nxt = mmscale_pkg::MODE_LOW;
    end else if (d_r >= r_r) begin
      mode_nxt = mmscale_pkg::MODE_HIGH;
    end else begin
      mode_nxt = mmscale_pkg::MODE_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_req_type == mmscale_pkg::REQ_SCALE) begin
      d_r   <= d_nxt;
      r_r   <= r_nxt;
      rem_r <= d_nxt[RB-1:0];
      q_r   <= '0;
    end else if (state_r == mmscale_pkg::ST_DIV) begin
      rem_r <= q_bit ? trial[RB-1:0] : rem_r << 1;
      q_r   <= {q_r[PB-2:0], q_bit};
      if (cnt_r == '0) begin
        mode_r <= mode_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (take) begin
      cnt_r <= '0;
    end else if (state_r == mmscale_pkg::ST_DIV) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // 256*d/r rounded down, minus one when the remainder shows 255*d/r lies below it
  always_comb begin
    case (mode_r)
      mmscale_pkg::MODE_FLAT: pix_nxt = '0;
      mmscale_pkg::MODE_LOW:  pix_nxt = '0;
      mmscale_pkg::MODE_HIGH: pix_nxt = mmscale_pkg::PIXEL_MAX;
      mmscale_pkg::MODE_DIV:  pix_nxt = (rem_r < d_r[RB-1:0]) ? q_r - 1'b1 : q_r;
      default:                pix_nxt = '0;
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_r      <= pix_nxt;
      degenerate_r <= (mode_r == mmscale_pkg::MODE_FLAT);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel      = pixel_r;
  assign out_degenerate = degenerate_r;

  // ---------------------------------------------------------------- assertions
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mmscale_pkg::ST_DIV) |-> in_stall)
    else $error("input taken while divider busy");

  a_scale_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_req_type == mmscale_pkg::REQ_SCALE)
      |=> (state_r == mmscale_pkg::ST_DIV && cnt_r == '0))
    else $error("scale transaction did not start the divider");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mmscale_pkg::ST_DIV && cnt_r == mmscale_pkg::DIV_LAST)
      |=> (state_r == mmscale_pkg::ST_FIX))
    else $error("divider did not finish after eight quotient bits");

  a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |-> (out_pixel == '0))
    else $error("degenerate result with nonzero pixel");

endmodule

[dv/min_max_scale_check.sv]
// checker for the min-max scale block: tracks the running range, predicts pixels, compares
`timescale 1ns / 100ps
module min_max_scale_check (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  input  logic                                       in_stall,
  input  logic                                       in_req_type,
  input  logic                                       in_first,
  input  logic signed [mmscale_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                       out_valid,
  input  logic                                       out_stall,
  input  logic [mmscale_pkg::PIXEL_BITS-1:0]         out_pixel,
  input  logic                                       out_degenerate,
  input  logic                                       cfg_we,
  input  logic [mmscale_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [mmscale_pkg::CFG_BITS-1:0]           cfg_wdata,
  output int                                         fail_count,
  output int                                         pending
);
  import mmscale_pkg::*;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  degenerate;
  } stretch_t;

  stretch_t stretch_q[$];

  logic signed [CFG_BITS-1:0] min_start_r;
  logic signed [CFG_BITS-1:0] max_start_r;
  run_t                       low_r;
  run_t                       high_r;

  // exact floor(255*(x-min)/(max-min)) on the current range
  function automatic stretch_t stretch_pixel(input logic signed [SAMPLE_BITS-1:0] x);
    stretch_t res;
    longint   off;
    longint   span;
    res = '0;
    if (high_r == low_r) begin
      res.degenerate = 1'b1;
    end else if (high_r > low_r) begin
      if (x <= low_r) begin
        res.pixel = '0;
      end else if (x >= high_r) begin
        res.pixel = PIXEL_MAX;
      end else begin
        off  = longint'(x) - longint'(low_r);
        span = longint'(high_r) - longint'(low_r);
        res.pixel = PIXEL_BITS'((longint'(PIXEL_MAX) * off) / span);
      end
    end
    // inverted range leaves pixel 0, degenerate 0
    return res;
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10)
      $display("%t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : watch
    stretch_t got;
    stretch_t want;
    if (!rst_n) begin
      min_start_r = MIN_START_RST;
      max_start_r = MAX_START_RST;
      low_r       = run_t'(MIN_START_RST);
      high_r      = run_t'(MAX_START_RST);
      stretch_q.delete();
      fail_count  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_START: min_start_r = cfg_wdata;
          CFG_MAX_START: max_start_r = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_req_type == REQ_MEASURE) begin
          if (in_first) begin
            low_r  = run_t'(min_start_r);
            high_r = run_t'(max_start_r);
          end
          if (in_sample > high_r) high_r = in_sample;
          if (in_sample < low_r)  low_r  = in_sample;
        end else begin
          stretch_q.insert(stretch_q.size(), stretch_pixel(in_sample));
        end
      end
      if (out_valid && !out_stall) begin
        got.pixel      = out_pixel;
        got.degenerate = out_degenerate;
        if (stretch_q.size() == 0) begin
          note_failure($sformatf("unexpected result: pixel %0d degenerate %0d",
                                 got.pixel, got.degenerate));
        end else begin
          want = stretch_q.pop_front();
          if (got.pixel !== want.pixel || got.degenerate !== want.degenerate)
            note_failure($sformatf(
              "result mismatch: expected pixel %0d degenerate %0d, got pixel %0d degenerate %0d",
              want.pixel, want.degenerate, got.pixel, got.degenerate));
        end
      end
    end
    pending <= stretch_q.size();
  end

endmodule

[dv/min_max_scale_to_8bit_test.sv]
// testbench top for the min-max scale block: directed and random two-pass stimulus, verdict
`timescale 1ns / 100ps
module min_max_scale_to_8bit_test;
  import mmscale_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [CFG_BITS-1:0]           CFG_HI    = {1'b0, {(CFG_BITS-1){1'b1}}};
  localparam logic [CFG_BITS-1:0]           CFG_LO    = {1'b1, {(CFG_BITS-1){1'b0}}};
  // cycles the block may still be busy after the last result (one divide plus slack)
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS   = 125;

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          in_valid    = 1'b0;
  logic                          in_req_type = REQ_MEASURE;
  logic                          in_first    = 1'b0;
  logic signed [SAMPLE_BITS-1:0] in_sample   = '0;
  logic                          out_stall   = 1'b0;
  logic                          cfg_we      = 1'b0;
  logic [CFG_IDX_BITS-1:0]       cfg_index   = CFG_MIN_START;
  logic [CFG_BITS-1:0]           cfg_wdata   = '0;

  logic                          in_stall;
  logic                          out_valid;
  logic [PIXEL_BITS-1:0]         out_pixel;
  logic                          out_degenerate;

  int fail_count;
  int pending;              // results still owed by the block, as registered by the checker
  int send_idle_pct = 0;    // chance per cycle that the sender holds off
  int stall_pct     = 0;    // chance per cycle that the receiver stalls
  int items_sent    = 0;

  min_max_scale_to_8bit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_first      (in_first),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel     (out_pixel),
    .out_degenerate(out_degenerate),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  min_max_scale_check checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_first      (in_first),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel     (out_pixel),
    .out_degenerate(out_degenerate),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver back-pressure, one decision per cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // one input transaction; valid is left high so back-to-back items never toggle it
  task automatic send_item(input logic req, input logic fst,
                           input logic signed [SAMPLE_BITS-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_first    <= fst;
    in_sample   <= smp;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // stop sending, wait for every owed result, then let the divider go quiet
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both start registers, back to back; only called while the block is idle
  task automatic write_starts(input logic [CFG_BITS-1:0] lo, input logic [CFG_BITS-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_START;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_MAX_START;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one array: measure pass then scale pass over the same data, with some noise
  task automatic run_array();
    logic signed [SAMPLE_BITS-1:0] vals[16];
    logic signed [SAMPLE_BITS-1:0] base;
    logic signed [SAMPLE_BITS-1:0] v;
    int n;
    int flavor;
    int spread;
    n      = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 16);
    flavor = $urandom_range(3);
    base   = $urandom;
    spread = $urandom_range(31);
    for (int i = 0; i < n; i++) begin
      case (flavor)
        0: vals[i] = $urandom;
        1: vals[i] = base + ($urandom & ((32'd1 << spread) - 32'd1));
        2: vals[i] = $urandom_range(40) - 20;
        default: vals[i] = $urandom_range(1) ? SAMPLE_HI - $urandom_range(3)
                                             : SAMPLE_LO + $urandom_range(3);
      endcase
    end
    // now and then skip the measure pass so the old range is reused
    if ($urandom_range(7) != 0) begin
      for (int i = 0; i < n; i++)
        // an occasional pass without the first flag keeps growing the old range
        send_item(REQ_MEASURE, (i == 0) && ($urandom_range(9) != 0), vals[i]);
    end
    for (int i = 0; i < n; i++) begin
      v = vals[i];
      case ($urandom_range(9))
        0: v = $urandom;
        1: v = vals[i] - 1;
        2: v = vals[i] + 1;
        default: ;
      endcase
      // first flag on a scale transaction must be ignored
      send_item(REQ_SCALE, $urandom_range(4) == 0, v);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset range is inverted: pixel 0, not degenerate, first flag ignored on scale
    send_item(REQ_SCALE,   1'b0, 500);
    send_item(REQ_SCALE,   1'b1, SAMPLE_HI);
    // single sample gives a flat range
    send_item(REQ_MEASURE, 1'b1, 7);
    send_item(REQ_SCALE,   1'b0, 7);
    send_item(REQ_SCALE,   1'b0, SAMPLE_LO);
    // widest possible range
    send_item(REQ_MEASURE, 1'b0, SAMPLE_LO);
    send_item(REQ_MEASURE, 1'b0, SAMPLE_HI);
    send_item(REQ_SCALE,   1'b0, SAMPLE_LO);
    send_item(REQ_SCALE,   1'b0, SAMPLE_LO + 1);
    send_item(REQ_SCALE,   1'b0, -1);
    send_item(REQ_SCALE,   1'b0, 0);
    send_item(REQ_SCALE,   1'b0, SAMPLE_HI - 1);
    send_item(REQ_SCALE,   1'b0, SAMPLE_HI);
    // small range, points below, inside and above it
    send_item(REQ_MEASURE, 1'b1, 100);
    send_item(REQ_MEASURE, 1'b0, 200);
    send_item(REQ_SCALE,   1'b0, 99);
    send_item(REQ_SCALE,   1'b0, 150);
    send_item(REQ_SCALE,   1'b0, 199);
    send_item(REQ_SCALE,   1'b0, 201);
    drain();

    // extreme start values, both orders
    write_starts(CFG_HI, CFG_LO);
    send_item(REQ_MEASURE, 1'b1, -3);
    send_item(REQ_SCALE,   1'b0, -3);
    drain();
    write_starts(CFG_LO, CFG_HI);
    send_item(REQ_MEASURE, 1'b1, 0);
    send_item(REQ_SCALE,   1'b0, 0);

    // random arrays under four idling patterns; each phase starts from an idle block
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
      drain();
      case ($urandom_range(3))
        0: write_starts(MIN_START_RST, MAX_START_RST);
        1: write_starts(CFG_HI, CFG_LO);
        2: write_starts(CFG_LO, CFG_HI);
        default: write_starts($urandom, $urandom);
      endcase
      begin : phase_items
        int target;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target)
          run_array();
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
